/* rtl/odse_pkg.sv */
// Package for the odometry speed estimator: field layout, states, trig table and helpers.
`timescale 1ns / 1ps
package odse_pkg;

    // Field widths of one sample and one result
    localparam int TIME_FIELD_W = 32;
    localparam int POS_FIELD_W  = 16;
    localparam int HEAD_W       = 15;
    localparam int SPEED_W      = 24;

    // Bit positions inside s_tdata / m_tdata
    localparam int TIME_LSB    = 0;
    localparam int X_LSB       = 32;
    localparam int Y_LSB       = 48;
    localparam int HEAD_LSB    = 64;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;

    // Arithmetic constants
    localparam int FRAC_BITS  = 16;           // fraction bits of the distance root
    localparam int TRIG_MAG_W = 15;           // magnitude bits of a Q1.15 sine
    localparam int DIV_STEPS  = SPEED_W + 1;  // one extra quotient bit flags overflow

    localparam logic [SPEED_W-1:0] THRESH_RESET = 24'd328;

    // Angles in 1/64 degree
    localparam logic [HEAD_W-1:0] QUARTER_TURN       = 15'd5760;
    localparam logic [HEAD_W-1:0] HALF_TURN          = 15'd11520;
    localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 15'd17280;
    localparam logic [HEAD_W-1:0] FULL_TURN          = 15'd23040;

    // Quarter-wave sine in Q1.15, one entry per degree
    localparam logic [14:0] SINE_Q15 [0:90] = '{
        15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
        15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
        15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
        15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
        15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
        15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
        15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
        15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
        15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
        15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
        15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
        15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
        15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ROOT,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Sine over a quarter wave, u in 0..5760, linear interpolation inside a degree
    function automatic logic [14:0] quarter_sine(input logic [12:0] u);
        logic [6:0]  idx;
        logic [5:0]  frac;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [9:0]  diff;
        logic [15:0] prod;
        logic [16:0] rnd;
        idx  = u[12:6];
        frac = u[5:0];
        lo   = SINE_Q15[idx];
        hi   = lo;
        diff = '0;
        prod = '0;
        rnd  = '0;
        if (idx >= 7'd90) begin
            quarter_sine = SINE_Q15[90];
        end else begin
            hi   = SINE_Q15[idx + 7'd1];
            diff = 10'(hi - lo);
            prod = 16'(diff) * 16'(frac);
            rnd  = 17'(prod) + 17'd32;
            quarter_sine = lo + 15'(rnd[16:6]);
        end
    endfunction

    // Full-circle sine, a in 0..23039; result in -32767..32767
    function automatic logic signed [15:0] sine_of(input logic [HEAD_W-1:0] a);
        logic [HEAD_W-1:0] u;
        logic              neg;
        logic [14:0]       mag;
        if (a < QUARTER_TURN) begin
            u   = a;
            neg = 1'b0;
        end else if (a < HALF_TURN) begin
            u   = HALF_TURN - a;
            neg = 1'b0;
        end else if (a < THREE_QUARTER_TURN) begin
            u   = a - HALF_TURN;
            neg = 1'b1;
        end else begin
            u   = FULL_TURN - a;
            neg = 1'b1;
        end
        mag = quarter_sine(u[12:0]);
        sine_of = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

/* rtl/odse_sqrt.sv */
// Bit-serial integer square root with FRAC_BITS extra fraction bits, one root bit per cycle.
`timescale 1ns / 1ps
module odse_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [RAD_W-1:0]                       radicand,
    output logic                                   done,
    output logic [RAD_W/2+odse_pkg::FRAC_BITS-1:0] root
);

    localparam int ROOT_W = RAD_W / 2 + odse_pkg::FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down the next pair of radicand bits and try the next root bit
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Radicand drains to zeros, which supply the fraction pairs
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = take ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], take};
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/odometry_speed_direction_estimator.sv */
// Top level: speed and direction from successive odometry samples, bit-serial datapath.
// Steps: prep, the serial square/dot unit, the POS_BITS+17-step square root, the 25-step
// restoring divider, update and hand-off run in turn; a sample with zero elapsed time goes
// from prep straight to hand-off. A new sample is taken only once the last one is handed off,
// and the hand-off waits while the output register is full and m_tready is low.
// Reset (aresetn low, synchronous): previous sample at time 0 and (0,0), speed 0, forward 1.
`timescale 1ns / 1ps
module odometry_speed_direction_estimator #(
    parameter int POS_BITS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: time_ms[31:0], x_pos[47:32], y_pos[63:48], heading[78:64], zero[79]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [odse_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: speed[23:0], moving_forward[24], zero[31:25]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [odse_pkg::OUT_TDATA_W-1:0] m_tdata,
    // speed threshold write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [odse_pkg::SPEED_W-1:0]     cfg_data
);

    localparam int SQ_W      = 2 * POS_BITS + 1;
    localparam int RAD_W     = 2 * POS_BITS + 2;
    localparam int ROOT_W    = RAD_W / 2 + odse_pkg::FRAC_BITS;
    localparam int DOT_W     = POS_BITS + 18;
    localparam int MUL_STEPS = (POS_BITS > odse_pkg::TRIG_MAG_W) ? POS_BITS
                                                                 : odse_pkg::TRIG_MAG_W;
    localparam int CNT_MAX   = (MUL_STEPS > odse_pkg::DIV_STEPS) ? MUL_STEPS
                                                                 : odse_pkg::DIV_STEPS;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int DV_W      = (ROOT_W > TIME_BITS + odse_pkg::DIV_STEPS) ? ROOT_W
                                   : TIME_BITS + odse_pkg::DIV_STEPS;
    localparam int EXT_W     = (POS_BITS > odse_pkg::POS_FIELD_W) ? POS_BITS
                                                                  : odse_pkg::POS_FIELD_W;
    localparam int SW        = odse_pkg::SPEED_W;
    localparam int HW        = odse_pkg::HEAD_W;
    localparam int TW        = odse_pkg::TRIG_MAG_W;

    // Control and held state
    odse_pkg::state_t               state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]           last_time_reg, last_time_next;
    logic [POS_BITS-1:0]            last_x_reg, last_x_next;
    logic [POS_BITS-1:0]            last_y_reg, last_y_next;
    logic [SW-1:0]                  thresh_reg, thresh_next;
    logic [SW-1:0]                  held_speed_reg, held_speed_next;
    logic                           held_fwd_reg, held_fwd_next;
    logic                           root_start_reg, root_start_next;
    logic                           out_valid_reg, out_valid_next;

    // Datapath
    logic [TIME_BITS-1:0]           dt_reg, dt_next;
    logic [POS_BITS:0]              dx_reg, dx_next;
    logic [POS_BITS:0]              dy_reg, dy_next;
    logic [HW-1:0]                  ang_reg, ang_next;
    logic [HW-1:0]                  angc_reg, angc_next;
    logic [TW-1:0]                  sin_sh_reg, sin_sh_next;
    logic [TW-1:0]                  cos_sh_reg, cos_sh_next;
    logic                           sin_neg_reg, sin_neg_next;
    logic                           cos_neg_reg, cos_neg_next;
    logic [POS_BITS-1:0]            ax_reg, ax_next;
    logic [POS_BITS-1:0]            ay_reg, ay_next;
    logic [POS_BITS-1:0]            ax_sh_reg, ax_sh_next;
    logic [POS_BITS-1:0]            ay_sh_reg, ay_sh_next;
    logic [SQ_W-1:0]                sq_acc_reg, sq_acc_next;
    logic [DOT_W-1:0]               dot_acc_reg, dot_acc_next;
    logic [DV_W-1:0]                rem_reg, rem_next;
    logic [DV_W-1:0]                div_reg, div_next;
    logic [odse_pkg::DIV_STEPS-1:0] quo_reg, quo_next;
    logic [SW-1:0]                  out_speed_reg, out_speed_next;
    logic                           out_fwd_reg, out_fwd_next;

    // Input field decode
    logic [TIME_BITS-1:0]           in_time;
    logic [EXT_W-1:0]               x_ext;
    logic [EXT_W-1:0]               y_ext;
    logic [POS_BITS-1:0]            in_x;
    logic [POS_BITS-1:0]            in_y;
    logic [HW-1:0]                  head;
    logic [HW-1:0]                  in_ang;
    logic [HW:0]                    angc_sum;
    logic [HW-1:0]                  in_angc;

    // Combinational helpers
    logic signed [15:0]             sin_val;
    logic signed [15:0]             cos_val;
    logic [15:0]                    sin_abs;
    logic [15:0]                    cos_abs;
    logic [POS_BITS:0]              dx_neg;
    logic [POS_BITS:0]              dy_neg;
    logic [POS_BITS-1:0]            ax_mag;
    logic [POS_BITS-1:0]            ay_mag;
    logic [SQ_W-1:0]                sq_sum;
    logic [DOT_W-1:0]               dxe;
    logic [DOT_W-1:0]               dye;
    logic [DOT_W-1:0]               dot_cx;
    logic [DOT_W-1:0]               dot_sy;
    logic [DOT_W-1:0]               dot_sum;
    logic                           dot_pos;
    logic                           div_ge;
    logic [SW-1:0]                  speed_new;
    logic                           root_done;
    logic [ROOT_W-1:0]              root_val;
    logic                           in_beat;

    // Field decode: low POS_BITS of a position field taken as signed
    assign in_time  = s_tdata[odse_pkg::TIME_LSB +: TIME_BITS];
    assign x_ext    = EXT_W'(s_tdata[odse_pkg::X_LSB +: odse_pkg::POS_FIELD_W]);
    assign y_ext    = EXT_W'(s_tdata[odse_pkg::Y_LSB +: odse_pkg::POS_FIELD_W]);
    assign in_x     = x_ext[POS_BITS-1:0];
    assign in_y     = y_ext[POS_BITS-1:0];
    assign head     = s_tdata[odse_pkg::HEAD_LSB +: HW];

    // Heading to 0..23039 and the cosine angle a quarter turn ahead
    assign in_ang   = head[HW-1] ? (head + odse_pkg::FULL_TURN) : head;
    assign angc_sum = {1'b0, in_ang} + {1'b0, odse_pkg::QUARTER_TURN};
    assign in_angc  = (angc_sum >= {1'b0, odse_pkg::FULL_TURN})
                    ? HW'(angc_sum - {1'b0, odse_pkg::FULL_TURN}) : angc_sum[HW-1:0];

    // Sine and cosine, split into magnitude and sign for the serial dot product
    assign sin_val  = odse_pkg::sine_of(ang_reg);
    assign cos_val  = odse_pkg::sine_of(angc_reg);
    assign sin_abs  = sin_val[15] ? 16'(-sin_val) : 16'(sin_val);
    assign cos_abs  = cos_val[15] ? 16'(-cos_val) : 16'(cos_val);

    // Magnitudes of the position deltas
    assign dx_neg   = -dx_reg;
    assign dy_neg   = -dy_reg;
    assign ax_mag   = dx_reg[POS_BITS] ? dx_neg[POS_BITS-1:0] : dx_reg[POS_BITS-1:0];
    assign ay_mag   = dy_reg[POS_BITS] ? dy_neg[POS_BITS-1:0] : dy_reg[POS_BITS-1:0];

    // Serial squares, MSB first: acc = 2*acc + ax*bit(ax) + ay*bit(ay)
    assign sq_sum   = {sq_acc_reg[SQ_W-2:0], 1'b0}
                    + SQ_W'(ax_sh_reg[POS_BITS-1] ? ax_reg : '0)
                    + SQ_W'(ay_sh_reg[POS_BITS-1] ? ay_reg : '0);

    // Serial dot product, MSB first over the trig magnitudes, signs folded in
    assign dxe      = {{(DOT_W - POS_BITS - 1){dx_reg[POS_BITS]}}, dx_reg};
    assign dye      = {{(DOT_W - POS_BITS - 1){dy_reg[POS_BITS]}}, dy_reg};
    assign dot_cx   = cos_sh_reg[TW-1] ? (cos_neg_reg ? -dxe : dxe) : '0;
    assign dot_sy   = sin_sh_reg[TW-1] ? (sin_neg_reg ? -dye : dye) : '0;
    assign dot_sum  = {dot_acc_reg[DOT_W-2:0], 1'b0} + dot_cx + dot_sy;
    assign dot_pos  = !dot_acc_reg[DOT_W-1] && (dot_acc_reg != '0);

    // Restoring divide step and saturated speed
    assign div_ge    = (rem_reg >= div_reg);
    assign speed_new = quo_reg[odse_pkg::DIV_STEPS-1] ? '1 : quo_reg[SW-1:0];

    assign in_beat   = s_tvalid && s_tready;

    odse_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start_reg),
        .radicand (RAD_W'(sq_acc_reg)),
        .done     (root_done),
        .root     (root_val)
    );

    // Sequencer and next-state logic
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        last_time_next  = last_time_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        thresh_next     = thresh_reg;
        held_speed_next = held_speed_reg;
        held_fwd_next   = held_fwd_reg;
        root_start_next = 1'b0;
        out_valid_next  = out_valid_reg;
        dt_next         = dt_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        ang_next        = ang_reg;
        angc_next       = angc_reg;
        sin_sh_next     = sin_sh_reg;
        cos_sh_next     = cos_sh_reg;
        sin_neg_next    = sin_neg_reg;
        cos_neg_next    = cos_neg_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        ax_sh_next      = ax_sh_reg;
        ay_sh_next      = ay_sh_reg;
        sq_acc_next     = sq_acc_reg;
        dot_acc_next    = dot_acc_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        out_speed_next  = out_speed_reg;
        out_fwd_next    = out_fwd_reg;

        if (cfg_valid) begin
            thresh_next = cfg_data;
        end

        // Output register drains independently of the sequencer
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            odse_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    dt_next        = in_time - last_time_reg;
                    dx_next        = {in_x[POS_BITS-1], in_x}
                                   - {last_x_reg[POS_BITS-1], last_x_reg};
                    dy_next        = {in_y[POS_BITS-1], in_y}
                                   - {last_y_reg[POS_BITS-1], last_y_reg};
                    ang_next       = in_ang;
                    angc_next      = in_angc;
                    last_time_next = in_time;
                    last_x_next    = in_x;
                    last_y_next    = in_y;
                    state_next     = odse_pkg::ST_PREP;
                end
            end
            odse_pkg::ST_PREP: begin
                sin_sh_next  = sin_abs[TW-1:0];
                cos_sh_next  = cos_abs[TW-1:0];
                sin_neg_next = sin_val[15];
                cos_neg_next = cos_val[15];
                ax_next      = ax_mag;
                ay_next      = ay_mag;
                ax_sh_next   = ax_mag;
                ay_sh_next   = ay_mag;
                sq_acc_next  = '0;
                dot_acc_next = '0;
                cnt_next     = '0;
                state_next   = (dt_reg == '0) ? odse_pkg::ST_DONE : odse_pkg::ST_MUL;
            end
            odse_pkg::ST_MUL: begin
                if (cnt_reg < CNT_W'(POS_BITS)) begin
                    sq_acc_next = sq_sum;
                    ax_sh_next  = {ax_sh_reg[POS_BITS-2:0], 1'b0};
                    ay_sh_next  = {ay_sh_reg[POS_BITS-2:0], 1'b0};
                end
                if (cnt_reg < CNT_W'(TW)) begin
                    dot_acc_next = dot_sum;
                    sin_sh_next  = {sin_sh_reg[TW-2:0], 1'b0};
                    cos_sh_next  = {cos_sh_reg[TW-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    root_start_next = 1'b1;
                    state_next      = odse_pkg::ST_ROOT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            odse_pkg::ST_ROOT: begin
                if (root_done) begin
                    rem_next   = DV_W'(root_val);
                    div_next   = DV_W'(dt_reg) << (odse_pkg::DIV_STEPS - 1);
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = odse_pkg::ST_DIV;
                end
            end
            odse_pkg::ST_DIV: begin
                if (div_ge) begin
                    rem_next = rem_reg - div_reg;
                end
                quo_next = {quo_reg[odse_pkg::DIV_STEPS-2:0], div_ge};
                div_next = div_reg >> 1;
                if (cnt_reg == CNT_W'(odse_pkg::DIV_STEPS - 1)) begin
                    state_next = odse_pkg::ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            odse_pkg::ST_UPDATE: begin
                held_speed_next = speed_new;
                if (speed_new > thresh_reg) begin
                    held_fwd_next = dot_pos;
                end
                state_next = odse_pkg::ST_DONE;
            end
            odse_pkg::ST_DONE: begin
                // Hand the held values to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_speed_next = held_speed_reg;
                    out_fwd_next   = held_fwd_reg;
                    state_next     = odse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = odse_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= odse_pkg::ST_IDLE;
            last_time_reg  <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            thresh_reg     <= odse_pkg::THRESH_RESET;
            held_speed_reg <= '0;
            held_fwd_reg   <= 1'b1;
            root_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_time_reg  <= last_time_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            thresh_reg     <= thresh_next;
            held_speed_reg <= held_speed_next;
            held_fwd_reg   <= held_fwd_next;
            root_start_reg <= root_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        dt_reg        <= dt_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        ang_reg       <= ang_next;
        angc_reg      <= angc_next;
        sin_sh_reg    <= sin_sh_next;
        cos_sh_reg    <= cos_sh_next;
        sin_neg_reg   <= sin_neg_next;
        cos_neg_reg   <= cos_neg_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        ax_sh_reg     <= ax_sh_next;
        ay_sh_reg     <= ay_sh_next;
        sq_acc_reg    <= sq_acc_next;
        dot_acc_reg   <= dot_acc_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        out_speed_reg <= out_speed_next;
        out_fwd_reg   <= out_fwd_next;
    end

    assign s_tready  = (state_reg == odse_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = odse_pkg::OUT_TDATA_W'({out_fwd_reg, out_speed_reg});
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // An accepted beat always starts the preparation step
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == odse_pkg::ST_PREP))
        else $error("accepted beat did not start processing");

    // A new result appears only out of the hand-off state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == odse_pkg::ST_DONE))
        else $error("result raised outside hand-off");

    // The root unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> (state_reg == odse_pkg::ST_ROOT))
        else $error("root finished while sequencer not waiting");

    // Held speed changes only in the update step
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (held_speed_reg != $past(held_speed_reg)))
        |-> $past(state_reg == odse_pkg::ST_UPDATE))
        else $error("held speed changed outside update");

    // Direction flips only on an update whose speed is above the threshold
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (held_fwd_reg != $past(held_fwd_reg)))
        |-> ($past(state_reg == odse_pkg::ST_UPDATE) && (held_speed_reg > $past(thresh_reg))))
        else $error("direction changed without speed above threshold");
`endif

endmodule
